// ===== src/pdc16_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pdc16_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned INDEX_W    = 9;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CRC_W-1:0]   CRC_POLY   = 16'h1021;
    localparam logic [CRC_W-1:0]   CRC_INIT   = 16'h0000;
    localparam logic [BYTE_W-1:0]  LFSR_SEED  = 8'hFF;
    localparam logic [INDEX_W-1:0] INDEX_MAX  = 9'd511;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PAYLOAD_LENGTH = 1'b0,
        REG_CRC_PRESENT    = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [BYTE_W-1:0]  whiten;
        logic [CRC_W-1:0]   crc_main;
        logic [CRC_W-1:0]   crc_short;
        logic [INDEX_W-1:0] byte_index;
        logic [BYTE_W-1:0]  tail_first;
        logic [BYTE_W-1:0]  tail_second;
        logic [1:0]         tail_flags;
        logic [CRC_W-1:0]   rx_crc;
        logic [1:0]         rx_count;
    } t_frame_state;

    localparam t_frame_state FRAME_CLEAR = '{
        whiten:      LFSR_SEED,
        crc_main:    CRC_INIT,
        crc_short:   CRC_INIT,
        byte_index:  '0,
        tail_first:  '0,
        tail_second: '0,
        tail_flags:  '0,
        rx_crc:      '0,
        rx_count:    '0
    };

    // msb first, one bit per step
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        logic             fb;
        crc = crc_in;
        for (int k = 0; k < BYTE_W; k++) begin
            fb  = crc[CRC_W-1] ^ data[BYTE_W-1-k];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic logic [BYTE_W-1:0] lfsr_next(input logic [BYTE_W-1:0] s);
        return {s[6:0], s[7] ^ s[5] ^ s[4] ^ s[3]};
    endfunction

endpackage

`default_nettype wire

// ===== src/payload_dewhiten_crc16_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel     dir  handshake                      payload
// s_axis      in   i_s_axis_tvalid/o_s_axis_tready tdata raw byte, tlast last byte
// m_axis      out  o_m_axis_tvalid/i_m_axis_tready tdata crc results, tlast frame end,
//                                                 tuser crc byte flag
// cfg         in   i_cfg_we                       i_cfg_addr, i_cfg_data
//
// one beat per cycle sustained while m_axis accepts; a result appears in the cycle after its input beat
// dewhitening and the per-byte crc16 steps sit between the input beat and the output register
// input ready while the output register is empty or being drained
// synchronous active-low reset: payload length 0, crc_present 1, frame state cleared
// frame state returns to its cleared value after each last beat

module payload_dewhiten_crc16_check (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [pdc16_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,   // [7:0] frame byte
    input  wire logic                              i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [7:0] data_byte, [23:8] crc_computed, [39:24] crc_alternate,
    // [55:40] crc_received, [56] crc_available, [57] crc_ok, [58] crc_alternate_ok
    output logic [pdc16_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic                                   o_m_axis_tlast,
    output logic                                   o_m_axis_tuser,   // [0] crc byte flag
    input  wire logic                              i_cfg_we,
    input  wire logic [pdc16_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [pdc16_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pdc16_pkg::*;

    logic [BYTE_W-1:0]     r_frame_len;
    logic                  r_crc_present;
    t_frame_state          r_st;
    t_frame_state          n_st;
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [OUT_DATA_W-1:0] n_m_data;
    logic                  r_m_last;
    logic                  r_m_user;
    logic                  n_m_user;
    logic                  s_accept;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tlast  = r_m_last;
    assign o_m_axis_tuser  = r_m_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len   <= '0;
            r_crc_present <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_PAYLOAD_LENGTH: r_frame_len   <= i_cfg_data;
                REG_CRC_PRESENT:    r_crc_present <= i_cfg_data[0];
                default:            r_crc_present <= r_crc_present;
            endcase
        end
    end

    always_comb begin
        logic [INDEX_W-1:0] idx;
        logic [INDEX_W-1:0] pl;
        logic [INDEX_W-1:0] pl_end;
        logic [INDEX_W-1:0] pl_tail;
        logic [BYTE_W-1:0]  data;
        logic               in_payload;
        logic               is_crc;
        logic               avail;
        logic [CRC_W-1:0]   alt;
        logic [CRC_W-1:0]   rx;
        logic               ok;
        logic               alt_ok;

        n_st       = r_st;
        idx        = r_st.byte_index;
        pl         = {1'b0, r_frame_len};
        pl_end     = pl + INDEX_W'(2);
        pl_tail    = pl - INDEX_W'(2);
        in_payload = idx < pl;
        is_crc     = r_crc_present && !in_payload && idx < pl_end;
        data       = i_s_axis_tdata;

        if (in_payload) begin
            data          = i_s_axis_tdata ^ r_st.whiten;
            n_st.whiten   = lfsr_next(r_st.whiten);
            n_st.crc_main = crc16_byte(r_st.crc_main, data);
            if (pl >= INDEX_W'(2)) begin
                if (idx < pl_tail) begin
                    n_st.crc_short = crc16_byte(r_st.crc_short, data);
                end else if (idx == pl_tail) begin
                    n_st.tail_first    = data;
                    n_st.tail_flags[0] = 1'b1;
                end else begin
                    n_st.tail_second   = data;
                    n_st.tail_flags[1] = 1'b1;
                end
            end
        end else if (is_crc) begin
            if (idx == pl) begin
                n_st.rx_crc[7:0] = i_s_axis_tdata;
            end else begin
                n_st.rx_crc[15:8] = i_s_axis_tdata;
            end
            if (r_st.rx_count != 2'd2) begin
                n_st.rx_count = r_st.rx_count + 2'd1;
            end
        end

        if (idx != INDEX_MAX) begin
            n_st.byte_index = idx + INDEX_W'(1);
        end

        avail = r_crc_present && n_st.rx_count == 2'd2;
        rx    = avail ? n_st.rx_crc : '0;
        alt   = n_st.crc_short;
        if (pl >= INDEX_W'(2) && n_st.tail_flags == 2'b11) begin
            alt = alt ^ {n_st.tail_first, n_st.tail_second};
        end
        ok     = !r_crc_present || (avail && n_st.crc_main == rx);
        alt_ok = !r_crc_present || (avail && alt == rx);

        n_m_data       = '0;
        n_m_data[7:0]  = data;
        n_m_user       = is_crc;
        if (i_s_axis_tlast) begin
            n_m_data[23:8]  = n_st.crc_main;
            n_m_data[39:24] = alt;
            n_m_data[55:40] = rx;
            n_m_data[56]    = avail;
            n_m_data[57]    = ok;
            n_m_data[58]    = alt_ok;
            n_st            = FRAME_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= FRAME_CLEAR;
            r_m_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_st      <= n_st;
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_data <= n_m_data;
            r_m_last <= i_s_axis_tlast;
            r_m_user <= n_m_user;
        end
    end

    // frame state clears after the last beat
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && i_s_axis_tlast |=> r_st.byte_index == '0 && r_st.whiten == LFSR_SEED)
        else $error("frame state not cleared after last beat");

    // byte index only returns to zero at a frame end
    a_index_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && !i_s_axis_tlast |=> r_st.byte_index != '0)
        else $error("byte index wrapped mid-frame");

    // crc fields are zero away from the frame end
    a_mid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && !r_m_last |-> r_m_data[58:8] == '0)
        else $error("crc fields set on a mid-frame beat");

    // a passing check with a received crc means the values agree
    a_ok_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_last && r_m_data[56] && r_m_data[57]
            |-> r_m_data[23:8] == r_m_data[55:40])
        else $error("crc_ok set with mismatched crc");

endmodule

`default_nettype wire
